/* rtl/core/fat32ccw_pkg.sv */
// Shared types and constants for the FAT32 cluster chain walker.
package fat32ccw_pkg;

	localparam logic [31:0] END_OF_CHAIN = 32'h0FFF_FFF8;
	localparam logic [31:0] CLUSTER_MASK = 32'h0FFF_FFFF;
	localparam logic [31:0] BASE_CLUSTER = 32'd2;
	localparam int unsigned LINK_BYTES_LOG2 = 2;
	localparam logic [3:0] SIZE_LOG2_MIN = 4'd9;
	localparam logic [3:0] SIZE_LOG2_MAX = 4'd12;

	localparam logic [2:0] SPC_LOG2_RESET = 3'd3;
	localparam logic [31:0] FIRST_DATA_RESET = 32'd0;
	localparam logic [15:0] RESERVED_RESET = 16'd32;
	localparam logic [3:0] SIZE_LOG2_RESET = 4'd9;

	typedef enum logic [1:0] {
		REG_SPC_LOG2 = 2'd0,
		REG_FIRST_DATA = 2'd1,
		REG_RESERVED = 2'd2,
		REG_SIZE_LOG2 = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] spc_log2;
		logic [31:0] first_data;
		logic [15:0] reserved;
		logic [3:0] size_log2;
	} cfg_t;

	typedef struct packed {
		logic is_end;
		logic [31:0] base;
		logic [31:0] fsec;
		logic [11:0] foff;
	} prep_t;

endpackage

/* rtl/core/fat32ccw_prep.sv */
// Cluster decode: end-of-chain test, first data sector and FAT link location.
module fat32ccw_prep (
	input logic kind,
	input logic [31:0] cluster_value,
	input fat32ccw_pkg::cfg_t cfg,
	output fat32ccw_pkg::prep_t prep
);

	logic [31:0] cluster;
	logic [31:0] link;
	logic [3:0] size_log2;
	logic [12:0] one_sh;
	logic [11:0] off_mask;

	always_comb begin
		cluster = kind ? (cluster_value & fat32ccw_pkg::CLUSTER_MASK) : cluster_value;
		priority if (cfg.size_log2 < fat32ccw_pkg::SIZE_LOG2_MIN) begin
			size_log2 = fat32ccw_pkg::SIZE_LOG2_MIN;
		end else if (cfg.size_log2 > fat32ccw_pkg::SIZE_LOG2_MAX) begin
			size_log2 = fat32ccw_pkg::SIZE_LOG2_MAX;
		end else begin
			size_log2 = cfg.size_log2;
		end
		link = cluster << fat32ccw_pkg::LINK_BYTES_LOG2;
		one_sh = 13'd1 << size_log2;
		off_mask = 12'(one_sh - 13'd1);

		prep.is_end = (cluster >= fat32ccw_pkg::END_OF_CHAIN);
		prep.base = ((cluster - fat32ccw_pkg::BASE_CLUSTER) << cfg.spc_log2)
			+ cfg.first_data;
		prep.fsec = {16'd0, cfg.reserved} + (link >> size_log2);
		prep.foff = link[11:0] & off_mask;
	end

endmodule

/* rtl/core/fat32_cluster_chain_walker.sv */
// Top level of the FAT32 cluster chain walker: config registers, cluster stage, result register.
// Items are registered in the cluster stage. Throughput: one result beat per cycle unless
// out_ready stalls; a data cluster emits min(2^sectors_per_cluster_log2, MAX_SECTORS_PER_CLUSTER)
// beats, an end-of-chain item one beat, set by the sector counter.
// The next item is accepted in the cycle its predecessor's last beat leaves the cluster stage.
// Reset: arst_n clears all control state and loads configuration defaults; no clearing pass.
module fat32_cluster_chain_walker #(
	parameter int unsigned MAX_SECTORS_PER_CLUSTER = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [31:0] cluster_value,
	output logic out_valid,
	input logic out_ready,
	output logic result_kind,
	output logic [31:0] data_sector,
	output logic [31:0] link_sector,
	output logic [11:0] link_offset,
	output logic last
);

	localparam int unsigned IDX_W = (MAX_SECTORS_PER_CLUSTER > 1) ?
		$clog2(MAX_SECTORS_PER_CLUSTER) : 1;
	localparam logic [7:0] MAX_CNT = 8'(MAX_SECTORS_PER_CLUSTER);

	fat32ccw_pkg::cfg_t cfg_q;
	fat32ccw_pkg::prep_t prep;

	logic valid_s1;
	logic end_s1;
	logic [31:0] base_s1;
	logic [31:0] fsec_s1;
	logic [11:0] foff_s1;
	logic [IDX_W-1:0] last_idx_s1;
	logic [IDX_W-1:0] idx_q;

	logic out_valid_q;
	logic result_kind_q;
	logic [31:0] data_sector_q;
	logic [31:0] link_sector_q;
	logic [11:0] link_offset_q;
	logic last_q;

	logic [7:0] cnt_full;
	logic [7:0] cnt_cap;
	logic [IDX_W-1:0] last_idx;
	logic in_accept;
	logic emit;
	logic s1_last;

	fat32ccw_prep u_prep (
		.kind(kind),
		.cluster_value(cluster_value),
		.cfg(cfg_q),
		.prep(prep)
	);

	always_comb begin
		cnt_full = 8'd1 << cfg_q.spc_log2;
		cnt_cap = (cnt_full > MAX_CNT) ? MAX_CNT : cnt_full;
		last_idx = IDX_W'(cnt_cap - 8'd1);
		emit = valid_s1 && (!out_valid_q || out_ready);
		s1_last = end_s1 || (idx_q == last_idx_s1);
		in_ready = !valid_s1 || (emit && s1_last);
		in_accept = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spc_log2 <= fat32ccw_pkg::SPC_LOG2_RESET;
			cfg_q.first_data <= fat32ccw_pkg::FIRST_DATA_RESET;
			cfg_q.reserved <= fat32ccw_pkg::RESERVED_RESET;
			cfg_q.size_log2 <= fat32ccw_pkg::SIZE_LOG2_RESET;
		end else if (cfg_we) begin
			unique case (fat32ccw_pkg::reg_idx_t'(cfg_index))
				fat32ccw_pkg::REG_SPC_LOG2: cfg_q.spc_log2 <= cfg_data[2:0];
				fat32ccw_pkg::REG_FIRST_DATA: cfg_q.first_data <= cfg_data;
				fat32ccw_pkg::REG_RESERVED: cfg_q.reserved <= cfg_data[15:0];
				fat32ccw_pkg::REG_SIZE_LOG2: cfg_q.size_log2 <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Cluster stage: hold one decoded cluster and step through its sectors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= '0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
			idx_q <= '0;
		end else if (emit) begin
			if (s1_last) begin
				valid_s1 <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			end_s1 <= prep.is_end;
			base_s1 <= prep.base;
			fsec_s1 <= prep.fsec;
			foff_s1 <= prep.foff;
			last_idx_s1 <= last_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_kind_q <= end_s1;
			data_sector_q <= end_s1 ? 32'd0 : (base_s1 + 32'(idx_q));
			link_sector_q <= (!end_s1 && s1_last) ? fsec_s1 : 32'd0;
			link_offset_q <= (!end_s1 && s1_last) ? foff_s1 : 12'd0;
			last_q <= s1_last;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = result_kind_q;
	assign data_sector = data_sector_q;
	assign link_sector = link_sector_q;
	assign link_offset = link_offset_q;
	assign last = last_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the FAT32 cluster chain walker: random chains, sector prediction, beat scoreboard.
module tb_top;

	localparam int unsigned MAX_SECTORS = 64;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 4;

	typedef enum bit {ITEM_START = 1'b0, ITEM_LINK = 1'b1} item_kind_t;
	typedef enum bit {BEAT_DATA = 1'b0, BEAT_END = 1'b1} beat_kind_t;

	typedef struct {
		logic result_kind;
		logic [31:0] data_sector;
		logic [31:0] link_sector;
		logic [11:0] link_offset;
		logic last;
	} sector_beat_t;

	class sector_book_t;
		fat32ccw_pkg::cfg_t regs;
		sector_beat_t pending[$];
		int unsigned mismatches;

		function new();
			regs.spc_log2 = fat32ccw_pkg::SPC_LOG2_RESET;
			regs.first_data = fat32ccw_pkg::FIRST_DATA_RESET;
			regs.reserved = fat32ccw_pkg::RESERVED_RESET;
			regs.size_log2 = fat32ccw_pkg::SIZE_LOG2_RESET;
			mismatches = 0;
		endfunction

		function void set_register(fat32ccw_pkg::reg_idx_t idx, logic [31:0] data);
			unique case (idx)
				fat32ccw_pkg::REG_SPC_LOG2: regs.spc_log2 = data[2:0];
				fat32ccw_pkg::REG_FIRST_DATA: regs.first_data = data;
				fat32ccw_pkg::REG_RESERVED: regs.reserved = data[15:0];
				fat32ccw_pkg::REG_SIZE_LOG2: regs.size_log2 = data[3:0];
				default: ;
			endcase
		endfunction

		function void note_cluster(item_kind_t k, logic [31:0] value);
			logic [31:0] clus;
			logic [31:0] first;
			logic [31:0] link;
			logic [31:0] fsec;
			logic [31:0] mask;
			logic [3:0] szl;
			int unsigned count;
			sector_beat_t b;
			clus = (k == ITEM_LINK) ? (value & fat32ccw_pkg::CLUSTER_MASK) : value;
			if (clus >= fat32ccw_pkg::END_OF_CHAIN) begin
				b = '{BEAT_END, 32'd0, 32'd0, 12'd0, 1'b1};
				pending.push_back(b);
				return;
			end
			count = 1 << regs.spc_log2;
			if (count > MAX_SECTORS)
				count = MAX_SECTORS;
			first = ((clus - fat32ccw_pkg::BASE_CLUSTER) << regs.spc_log2) + regs.first_data;
			szl = regs.size_log2;
			if (szl < fat32ccw_pkg::SIZE_LOG2_MIN)
				szl = fat32ccw_pkg::SIZE_LOG2_MIN;
			if (szl > fat32ccw_pkg::SIZE_LOG2_MAX)
				szl = fat32ccw_pkg::SIZE_LOG2_MAX;
			link = clus << fat32ccw_pkg::LINK_BYTES_LOG2;
			fsec = {16'd0, regs.reserved} + (link >> szl);
			mask = (32'd1 << szl) - 32'd1;
			for (int unsigned i = 0; i < count; i++) begin
				b.result_kind = BEAT_DATA;
				b.data_sector = first + i;
				b.last = (i + 1 == count);
				b.link_sector = b.last ? fsec : 32'd0;
				b.link_offset = b.last ? 12'(link & mask) : 12'd0;
				pending.push_back(b);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_sector(sector_beat_t got);
			sector_beat_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual kind %b sector %h",
					$time, got.result_kind, got.data_sector);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			compare_field("result_kind", want.result_kind, got.result_kind);
			compare_field("data_sector", want.data_sector, got.data_sector);
			compare_field("link_sector", want.link_sector, got.link_sector);
			compare_field("link_offset", want.link_offset, got.link_offset);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [31:0] cluster_value;
	logic out_valid;
	logic out_ready;
	logic result_kind;
	logic [31:0] data_sector;
	logic [31:0] link_sector;
	logic [11:0] link_offset;
	logic last;

	bit calm;
	bit hold_armed;
	bit hold_taken;
	sector_book_t book;

	fat32_cluster_chain_walker #(
		.MAX_SECTORS_PER_CLUSTER(MAX_SECTORS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.cluster_value(cluster_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.data_sector(data_sector),
		.link_sector(link_sector),
		.link_offset(link_offset),
		.last(last)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic write_register(fat32ccw_pkg::reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		book.set_register(idx, data);
	endtask

	task automatic load_config(logic [31:0] spc, logic [31:0] fds, logic [31:0] res,
		logic [31:0] szl);
		write_register(fat32ccw_pkg::REG_SPC_LOG2, spc);
		write_register(fat32ccw_pkg::REG_FIRST_DATA, fds);
		write_register(fat32ccw_pkg::REG_RESERVED, res);
		write_register(fat32ccw_pkg::REG_SIZE_LOG2, szl);
	endtask

	task automatic send_cluster(item_kind_t k, logic [31:0] value);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		cluster_value <= value;
		do @(posedge clk); while (!in_ready);
		book.note_cluster(k, value);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_cluster();
		unique case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(2, 4096);
			2: return $urandom();
			3: return fat32ccw_pkg::END_OF_CHAIN - $urandom_range(1, 8);
			4: return 32'h3FFF_FF00 + $urandom_range(0, 32'h1FF);
			default: return $urandom_range(2, 32'h0FFF_FFF7);
		endcase
	endfunction

	task automatic walk_chains(int unsigned items);
		int unsigned sent;
		int unsigned links;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 4) == 0) begin
				send_cluster(item_kind_t'($urandom_range(0, 1)), $urandom());
				sent++;
			end else begin
				links = $urandom_range(0, 4);
				send_cluster(ITEM_START, pick_cluster());
				repeat (links)
					send_cluster(ITEM_LINK, {4'($urandom()), 28'(pick_cluster())});
				if ($urandom_range(0, 3) != 0)
					send_cluster(ITEM_LINK, {4'($urandom()),
						28'(fat32ccw_pkg::END_OF_CHAIN + $urandom_range(0, 7))});
				sent += links + 2;
			end
		end
	endtask

	initial begin
		int unsigned pause;
		out_ready = 1'b0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				pause = calm ? 0 : $urandom_range(0, 4);
				if (pause > 0) begin
					@(negedge clk);
					out_ready <= 1'b0;
					repeat (pause - 1) @(negedge clk);
				end
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_sector('{result_kind, data_sector, link_sector, link_offset, last});
	end

	initial begin
		book = new();
		calm = 1'b0;
		hold_armed = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fat32ccw_pkg::REG_SPC_LOG2;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		kind = ITEM_START;
		cluster_value = 32'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_cluster(ITEM_START, 32'd0);
		send_cluster(ITEM_START, 32'd1);
		send_cluster(ITEM_START, fat32ccw_pkg::BASE_CLUSTER);
		send_cluster(ITEM_START, fat32ccw_pkg::END_OF_CHAIN - 32'd1);
		send_cluster(ITEM_START, fat32ccw_pkg::END_OF_CHAIN);
		send_cluster(ITEM_START, 32'hFFFF_FFFF);
		send_cluster(ITEM_START, 32'h4000_0003);
		send_cluster(ITEM_LINK, 32'hFFFF_FFFF);
		send_cluster(ITEM_LINK, 32'hF000_0002);
		send_cluster(ITEM_LINK, 32'hFFFF_FFF7);
		send_cluster(ITEM_LINK, fat32ccw_pkg::END_OF_CHAIN);
		send_cluster(ITEM_LINK, 32'd0);
		send_cluster(ITEM_LINK, 32'h0000_0481);
		settle();

		load_config(32'd0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'd12);
		send_cluster(ITEM_START, 32'd0);
		send_cluster(ITEM_LINK, 32'h0FFF_FFF7);
		walk_chains(18);
		settle();

		calm = 1'b1;
		load_config(32'd6, 32'd0, 32'd0, 32'd9);
		walk_chains(15);
		settle();

		calm = 1'b0;
		load_config(32'd7, $urandom(), $urandom_range(0, 16'hFFFF), 32'd0);
		send_cluster(ITEM_START, 32'd1);
		walk_chains(12);
		settle();

		load_config(32'd2, $urandom(), $urandom_range(0, 16'hFFFF), 32'd15);
		walk_chains(20);
		settle();

		load_config($urandom(), $urandom(), $urandom(), $urandom());
		hold_armed = 1'b1;
		walk_chains(30);
		settle();

		if (book.mismatches == 0 && book.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* filelist.f */
rtl/core/fat32ccw_pkg.sv
rtl/core/fat32ccw_prep.sv
rtl/core/fat32_cluster_chain_walker.sv
dv/tb_top.sv
